/* rtl/core/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg
// Shared sizes, item codes and controller/datapath link types for the
// integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

	// matrix size and derived widths
	localparam int DIM    = 4;
	localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int ADDR_W = $clog2(DIM * DIM);
	localparam int DATA_W = 32;

	// input item kinds
	localparam logic ACT_WRITE_B = 1'b0;
	localparam logic ACT_A_ELEM  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic             load;    // capture an A element
		logic             b_write; // write one B entry from the input
		logic             rd_en;   // issue one multiply-accumulate step
		logic [IDX_W-1:0] j;       // result column for step or emit
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic busy;                // multiply-accumulate steps in flight
	} dp_status_t;

endpackage

/* rtl/core/imm_datapath.sv */
// ----------------------------------------------------------------------------
// imm_datapath
// B store, shared multiplier and row accumulators. Each step reads one B
// entry, multiplies it by the held A element and adds it into one sum.
// ----------------------------------------------------------------------------
module imm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imm_pkg::ctrl_cmd_t               cmd,
	output imm_pkg::dp_status_t              status,
	input  logic [1:0]                       row_index,
	input  logic [1:0]                       col_index,
	input  logic signed [imm_pkg::DATA_W-1:0] value,
	output logic signed [imm_pkg::DATA_W-1:0] product_value
);
	import imm_pkg::*;

	logic [DATA_W-1:0] b_mem [DIM*DIM];
	logic [DATA_W-1:0] a_val_q;
	logic [IDX_W-1:0]  k_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_in_range;

	logic              v_s1;
	logic [IDX_W-1:0]  j_s1;
	logic [DATA_W-1:0] b_rd_s1;
	logic              v_s2;
	logic [IDX_W-1:0]  j_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q [DIM];

	// address generation
	assign wr_in_range = (int'(row_index) < DIM) && (int'(col_index) < DIM);
	assign wr_addr = ADDR_W'(int'(row_index) * DIM + int'(col_index));
	assign rd_addr = ADDR_W'(int'(k_q) * DIM + int'(cmd.j));

	// b store, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.b_write && wr_in_range) begin
			b_mem[wr_addr] <= value;
		end
		if (cmd.rd_en) begin
			b_rd_s1 <= b_mem[rd_addr];
		end
	end

	// held a element and its column
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_val_q <= value;
			k_q     <= IDX_W'(col_index);
		end
	end

	// step pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	// multiply stage, low 32 bits of the product
	always_ff @(posedge clk) begin
		j_s1 <= cmd.j;
		if (v_s1) begin
			prod_s2 <= DATA_W'(a_val_q * b_rd_s1);
			j_s2    <= j_s1;
		end
	end

	// row accumulators: cleared when a column 0 element is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.load && (col_index == 2'd0)) begin
			for (int i = 0; i < DIM; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[j_s2] <= acc_q[j_s2] + prod_s2;
		end
	end

	assign status.busy   = v_s1 | v_s2;
	assign product_value = acc_q[cmd.j];

endmodule

/* rtl/core/imm_ctrl.sv */
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer: takes items, steps the datapath through the DIM result columns
// of an A element and presents a finished row one result at a time.
// ----------------------------------------------------------------------------
module imm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      action,
	input  logic [1:0]                col_index,
	output logic                      in_stall,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                result_col,
	output logic                      row_done,
	output imm_pkg::ctrl_cmd_t        cmd,
	input  imm_pkg::dp_status_t       status
);
	import imm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [IDX_W-1:0] LAST_J = IDX_W'(DIM - 1);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             last_q;
	logic             in_xfer;
	logic             a_ok;

	assign in_xfer = in_valid && !in_stall;
	assign a_ok    = (action == ACT_A_ELEM) && (int'(col_index) < DIM);

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer && a_ok) begin
						state_q <= ST_RUN;
						last_q  <= (int'(col_index) == DIM - 1);
					end
				end
				ST_RUN: begin
					if (cnt_q == LAST_J) begin
						cnt_q   <= '0;
						state_q <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!status.busy) begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (cnt_q == LAST_J) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	assign cmd.load    = in_xfer && a_ok;
	assign cmd.b_write = in_xfer && (action == ACT_WRITE_B);
	assign cmd.rd_en   = (state_q == ST_RUN);
	assign cmd.j       = cnt_q;

	// handshakes and result tags
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = (state_q == ST_EMIT);
	assign result_col = 2'(cnt_q);
	assign row_done   = (cnt_q == LAST_J);

endmodule

/* rtl/core/integer_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Square integer matrix product C = A*B, one result row per A row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries action, row_index, col_index and
//   value. With action 0 a transfer writes B[row_index][col_index]; write
//   every B entry before streaming A. With action 1 a transfer delivers A
//   element k = col_index of the current row; column 0 restarts the sums.
//   An A element is worked in DIM steps of the single shared
//   multiply-accumulate (one B read, one multiply, one add per result
//   column), followed by the read and multiply pipeline drain.
//   After the element at column DIM-1 the output channel (out_valid/out_stall)
//   presents the DIM sums of the row in column order, one per cycle when not
//   stalled; row_done marks the last. In stays stalled until the row is taken.
//   A stalled result holds its value until transferred.
//   Reset clears the sums and returns to idle; the B store keeps no reset.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [1:0]                        row_index,
	input  logic [1:0]                        col_index,
	input  logic signed [imm_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [imm_pkg::DATA_W-1:0] product_value,
	output logic [1:0]                        result_col,
	output logic                              row_done
);
	import imm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer
	imm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.action     (action),
		.col_index  (col_index),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_col (result_col),
		.row_done   (row_done),
		.cmd        (cmd),
		.status     (status)
	);

	// store, multiplier and sums
	imm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.row_index     (row_index),
		.col_index     (col_index),
		.value         (value),
		.product_value (product_value)
	);

endmodule

/* rtl/core/imm_checker.sv */
// ----------------------------------------------------------------------------
// imm_checker
// Port level checks of result ordering and channel interplay.
// ----------------------------------------------------------------------------
module imm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [imm_pkg::DATA_W-1:0] product_value,
	input logic [1:0]                        result_col,
	input logic                              row_done
);
	import imm_pkg::*;

	// no input is taken while a row is being delivered
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while results pending");

	// a stalled result holds
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(product_value)
			&& $stable(result_col) && $stable(row_done))
		else $error("stalled result changed");

	// columns advance by one within a row
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !row_done |=>
			out_valid && (result_col == 2'($past(result_col) + 2'd1)))
		else $error("result columns out of order");

	// row ends on the last column and the row closes after it
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && row_done |=>
			!out_valid && ($past(result_col) == 2'(DIM - 1)))
		else $error("bad row end");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
